// File: hdl/swrd_pkg.sv
// Shared types and constants for the sliding window range detector.
package swrd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_WINDOW_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_RANGE_THRESHOLD = 2'd1;

    localparam logic [8:0]  WINDOW_LENGTH_RESET   = 9'd256;
    localparam logic [15:0] RANGE_THRESHOLD_RESET = 16'd0;

    // One buffered input beat
    typedef struct packed {
        logic               last_sample;
        logic signed [15:0] sample;
    } item_t;

    // Command from the sequencer to both monotonic queues
    typedef struct packed {
        logic start;
        logic clear;
    } qctl_t;

    // Status from one monotonic queue
    typedef struct packed {
        logic done;
    } qstat_t;

    // Monotonic queue sequencer states
    typedef enum logic [6:0] {
        Q_IDLE     = 7'b0000001,
        Q_EXP_RD   = 7'b0000010,
        Q_EXP_CHK  = 7'b0000100,
        Q_PUSH_RD  = 7'b0001000,
        Q_PUSH_CHK = 7'b0010000,
        Q_HEAD_RD  = 7'b0100000,
        Q_HEAD_WT  = 7'b1000000
    } qstate_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_RUN  = 3'b010,
        B_EMIT = 3'b100
    } bstate_t;

endpackage

// File: hdl/sliding_window_range_detector_top.sv
// Sliding window range detector top level: config registers and block wiring.
//
// Takes signed 16-bit samples and reports the 1-based start of every window of
// window_length samples whose max minus min is at or below range_threshold; on
// a sample flagged last with no qualifying window in the stream it reports
// none_found, then restarts counting. Each sample is processed in both monotonic
// queues together and waits on the busier of the two, whose time grows with every
// entry it drops (expired heads and dominated tails), since each queue step is one
// read of its entry memory with registered data. A two-beat input buffer and a
// result register let both sides stall independently. Config writes are always
// accepted and must be made while idle.
module sliding_window_range_detector_top import swrd_pkg::*; #(
    parameter  int WINDOW_MAX = 256,
    localparam int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    localparam int AGE_W      = $clog2(WINDOW_MAX + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample,
    input  logic               s_last_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_start_position,
    output logic               m_none_found,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic [8:0]         window_length_reg;
    logic [15:0]        range_threshold_reg;
    logic               item_valid;
    item_t              item;
    logic               item_pop;
    qctl_t              qctl;
    logic [SLOT_W-1:0]  q_slot;
    logic signed [15:0] q_value;
    logic [AGE_W-1:0]   q_len;
    qstat_t             max_stat, min_stat;
    logic signed [15:0] max_head, min_head;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg   <= WINDOW_LENGTH_RESET;
            range_threshold_reg <= RANGE_THRESHOLD_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WINDOW_LENGTH:   window_length_reg   <= cfg_data[8:0];
                CFG_RANGE_THRESHOLD: range_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    swrd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_last_sample (s_last_sample),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    swrd_mono_queue #(.WINDOW_MAX(WINDOW_MAX), .KEEP_MAX(1'b1)) u_max_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (qctl),
        .slot       (q_slot),
        .value      (q_value),
        .len        (q_len),
        .stat       (max_stat),
        .head_value (max_head)
    );

    swrd_mono_queue #(.WINDOW_MAX(WINDOW_MAX), .KEEP_MAX(1'b0)) u_min_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (qctl),
        .slot       (q_slot),
        .value      (q_value),
        .len        (q_len),
        .stat       (min_stat),
        .head_value (min_head)
    );

    swrd_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item_valid       (item_valid),
        .item             (item),
        .item_pop         (item_pop),
        .window_length    (window_length_reg),
        .range_threshold  (range_threshold_reg),
        .qctl             (qctl),
        .q_slot           (q_slot),
        .q_value          (q_value),
        .q_len            (q_len),
        .max_stat         (max_stat),
        .min_stat         (min_stat),
        .max_head         (max_head),
        .min_head         (min_head),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_start_position (m_start_position),
        .m_none_found     (m_none_found)
    );

`ifndef NO_ASSERTIONS
    // A none-found beat never carries a position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_none_found) |-> (m_start_position == 32'd0))
        else $error("none_found beat with nonzero start position");

    // When both queues report together, the window max is never below the min
    assert property (@(posedge aclk) disable iff (!aresetn)
        (max_stat.done && min_stat.done) |-> (max_head >= min_head))
        else $error("window max below window min");

    // A start command is only issued when a buffered beat is popped
    assert property (@(posedge aclk) disable iff (!aresetn)
        qctl.start |-> (item_pop && item_valid && !qctl.clear))
        else $error("queue start without a buffered beat");
`endif

endmodule

// File: hdl/swrd_front.sv
// Front end: accepts input beats into a two-entry queue for the back end.
module swrd_front import swrd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample,
    input  logic               s_last_sample,
    output logic               item_valid,
    output item_t              item,
    input  logic               item_pop
);

    item_t       buf_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;

    assign s_ready    = (count_reg != 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = buf_reg[rd_ptr_reg];
    assign push       = s_valid && s_ready;
    assign pop        = item_pop && item_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= '{last_sample: s_last_sample, sample: s_sample};
        end
    end

endmodule

// File: hdl/swrd_mono_queue.sv
// Monotonic queue of window entries (slot and value) for running max or min.
module swrd_mono_queue import swrd_pkg::*; #(
    parameter  int WINDOW_MAX = 256,
    parameter  bit KEEP_MAX   = 1'b1,
    localparam int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    localparam int PTR_W      = $clog2(2 * WINDOW_MAX),
    localparam int AGE_W      = $clog2(WINDOW_MAX + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  qctl_t              ctl,
    input  logic [SLOT_W-1:0]  slot,
    input  logic signed [15:0] value,
    input  logic [AGE_W-1:0]   len,
    output qstat_t             stat,
    output logic signed [15:0] head_value
);

    localparam int ENT_W = SLOT_W + 16;

    logic [ENT_W-1:0]   mem [WINDOW_MAX];
    logic [ENT_W-1:0]   rdata_reg;
    logic [SLOT_W-1:0]  raddr;
    logic               we;

    qstate_t            state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic signed [15:0] value_reg;
    logic [AGE_W-1:0]   len_reg;

    logic               empty;
    logic [PTR_W-1:0]   tail_back;
    logic [SLOT_W-1:0]  stored_slot;
    logic signed [15:0] stored_value;
    logic [AGE_W-1:0]   age;
    logic               dominated;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(2 * WINDOW_MAX - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(2 * WINDOW_MAX - 1) : p - PTR_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
        return (p >= PTR_W'(WINDOW_MAX)) ? SLOT_W'(p - PTR_W'(WINDOW_MAX)) : SLOT_W'(p);
    endfunction

    assign empty        = (head_reg == tail_reg);
    assign tail_back    = ptr_dec(tail_reg);
    assign stored_slot  = rdata_reg[ENT_W-1:16];
    assign stored_value = $signed(rdata_reg[15:0]);

    // Age of a stored slot seen from the slot being written: 1..WINDOW_MAX
    assign age = AGE_W'(slot_reg) - AGE_W'(stored_slot)
               + ((slot_reg > stored_slot) ? AGE_W'(0) : AGE_W'(WINDOW_MAX));

    assign dominated = KEEP_MAX ? (stored_value <= value_reg) : (stored_value >= value_reg);

    assign stat.done  = (state_reg == Q_HEAD_WT);
    assign head_value = stored_value;

    // Sequencer: clear on command, or expire old heads, pop dominated tails, push, fetch head
    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        raddr      = ptr_idx(head_reg);
        we         = 1'b0;
        case (state_reg)
            Q_IDLE: begin
                if (ctl.clear) begin
                    head_next = '0;
                    tail_next = '0;
                end else if (ctl.start) begin
                    state_next = Q_EXP_RD;
                end
            end
            Q_EXP_RD: begin
                state_next = empty ? Q_PUSH_RD : Q_EXP_CHK;
            end
            Q_EXP_CHK: begin
                if (age >= len_reg) begin
                    head_next  = ptr_inc(head_reg);
                    state_next = Q_EXP_RD;
                end else begin
                    state_next = Q_PUSH_RD;
                end
            end
            Q_PUSH_RD: begin
                raddr = ptr_idx(tail_back);
                if (empty) begin
                    we         = 1'b1;
                    tail_next  = ptr_inc(tail_reg);
                    state_next = Q_HEAD_RD;
                end else begin
                    state_next = Q_PUSH_CHK;
                end
            end
            Q_PUSH_CHK: begin
                if (dominated) begin
                    tail_next  = tail_back;
                    state_next = Q_PUSH_RD;
                end else begin
                    we         = 1'b1;
                    tail_next  = ptr_inc(tail_reg);
                    state_next = Q_HEAD_RD;
                end
            end
            Q_HEAD_RD: begin
                state_next = Q_HEAD_WT;
            end
            Q_HEAD_WT: begin
                state_next = Q_IDLE;
            end
            default: begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= Q_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    // Operands latched at start
    always_ff @(posedge aclk) begin
        if (state_reg == Q_IDLE && ctl.start) begin
            slot_reg  <= slot;
            value_reg <= value;
            len_reg   <= len;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[ptr_idx(tail_reg)] <= {slot_reg, value_reg};
        end
        rdata_reg <= mem[raddr];
    end

endmodule

// File: hdl/swrd_back.sv
// Back end: drives both queues per sample, checks the window, holds the result.
module swrd_back import swrd_pkg::*; #(
    parameter  int WINDOW_MAX = 256,
    localparam int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    localparam int AGE_W      = $clog2(WINDOW_MAX + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  item_t              item,
    output logic               item_pop,
    input  logic [8:0]         window_length,
    input  logic [15:0]        range_threshold,
    output qctl_t              qctl,
    output logic [SLOT_W-1:0]  q_slot,
    output logic signed [15:0] q_value,
    output logic [AGE_W-1:0]   q_len,
    input  qstat_t             max_stat,
    input  qstat_t             min_stat,
    input  logic signed [15:0] max_head,
    input  logic signed [15:0] min_head,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_start_position,
    output logic               m_none_found
);

    bstate_t            state_reg, state_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [31:0]        count_reg, count_next;
    logic               found_reg, found_next;
    logic               last_reg;
    logic [AGE_W-1:0]   len_reg;
    logic               max_done_reg, min_done_reg;
    logic signed [15:0] hi_reg, lo_reg;
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        start_reg;
    logic               none_reg;

    logic [31:0]        count_inc;
    logic [31:0]        len32;
    logic signed [16:0] span;
    logic               qualify;
    logic               emit_none;
    logic               out_free;
    logic               advance;

    // Window length clamped to 1..WINDOW_MAX
    always_comb begin
        if (window_length == 9'd0) begin
            q_len = AGE_W'(1);
        end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
            q_len = AGE_W'(WINDOW_MAX);
        end else begin
            q_len = AGE_W'(window_length);
        end
    end

    assign q_slot  = slot_reg;
    assign q_value = item.sample;

    // Window check on the updated count
    assign count_inc = (count_reg == 32'hFFFF_FFFF) ? count_reg : count_reg + 32'd1;
    assign len32     = 32'(len_reg);
    assign span      = 17'(hi_reg) - 17'(lo_reg);
    assign qualify   = (count_inc >= len32) && (span <= $signed({1'b0, range_threshold}));
    assign emit_none = last_reg && !found_reg && !qualify;
    assign out_free  = !m_valid_reg || m_ready;
    assign advance   = (state_reg == B_EMIT) && (out_free || !(qualify || emit_none));

    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        count_next   = count_reg;
        found_next   = found_reg;
        item_pop     = 1'b0;
        qctl         = '{start: 1'b0, clear: 1'b0};
        m_valid_next = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        case (state_reg)
            B_IDLE: begin
                if (item_valid) begin
                    item_pop   = 1'b1;
                    qctl.start = 1'b1;
                    state_next = B_RUN;
                end
            end
            B_RUN: begin
                if (max_done_reg && min_done_reg) begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT: begin
                if (advance) begin
                    state_next = B_IDLE;
                    slot_next  = (slot_reg == SLOT_W'(WINDOW_MAX - 1))
                               ? '0 : slot_reg + SLOT_W'(1);
                    count_next = count_inc;
                    found_next = found_reg || qualify;
                    if (qualify || emit_none) begin
                        m_valid_next = 1'b1;
                    end
                    // End of stream: start over
                    if (last_reg) begin
                        qctl.clear = 1'b1;
                        slot_next  = '0;
                        count_next = '0;
                        found_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            slot_reg     <= '0;
            count_reg    <= '0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            max_done_reg <= 1'b0;
            min_done_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            count_reg   <= count_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == B_IDLE) begin
                max_done_reg <= 1'b0;
                min_done_reg <= 1'b0;
            end else begin
                max_done_reg <= max_done_reg || max_stat.done;
                min_done_reg <= min_done_reg || min_stat.done;
            end
        end
    end

    // Per-sample operands and queue heads
    always_ff @(posedge aclk) begin
        if (item_pop) begin
            last_reg <= item.last_sample;
            len_reg  <= q_len;
        end
        if (max_stat.done) begin
            hi_reg <= max_head;
        end
        if (min_stat.done) begin
            lo_reg <= min_head;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (advance && (qualify || emit_none)) begin
            start_reg <= qualify ? (count_inc - len32 + 32'd1) : 32'd0;
            none_reg  <= !qualify;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_start_position = start_reg;
    assign m_none_found     = none_reg;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the sliding window range detector top level.
module tb_top;
    import swrd_pkg::*;

    localparam int RING_DEPTH = 256;
    localparam int DRAIN_CYCLES = 1200;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] start_position;
        logic        none_found;
    } window_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_sample;
    logic               s_last_sample;
    logic               m_valid;
    logic               m_ready;
    logic [31:0]        m_start_position;
    logic               m_none_found;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    // Predictor state
    logic [8:0]         cur_window_length;
    logic [15:0]        cur_range_threshold;
    logic signed [15:0] history[RING_DEPTH];
    int unsigned        write_slot;
    int unsigned        seen_count;
    bit                 found_quiet;
    window_result_t     expected_windows[$];

    int  fail_count;
    bit  no_idle;
    int  stall_left;
    int  idle_cycles;

    sliding_window_range_detector_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_last_sample    (s_last_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_start_position (m_start_position),
        .m_none_found     (m_none_found),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Work out the result a sample causes, if any
    task automatic predict_window_result(input logic signed [15:0] smp, input bit last);
        int unsigned        len;
        int unsigned        idx;
        logic signed [15:0] hi;
        logic signed [15:0] lo;
        int                 span;
        window_result_t     res;
        len = cur_window_length;
        if (len == 0) len = 1;
        if (len > RING_DEPTH) len = RING_DEPTH;
        history[write_slot] = smp;
        write_slot = (write_slot + 1) % RING_DEPTH;
        if (seen_count != 32'hFFFF_FFFF) seen_count++;
        if (seen_count >= len) begin
            hi = history[(write_slot + RING_DEPTH - 1) % RING_DEPTH];
            lo = hi;
            for (int k = 1; k <= len; k++) begin
                idx = (write_slot + RING_DEPTH - k) % RING_DEPTH;
                if (history[idx] > hi) hi = history[idx];
                if (history[idx] < lo) lo = history[idx];
            end
            span = int'(hi) - int'(lo);
            if (span <= int'(cur_range_threshold)) begin
                res.start_position = seen_count - len + 1;
                res.none_found = 1'b0;
                expected_windows.push_back(res);
                found_quiet = 1'b1;
            end
        end
        if (last) begin
            if (!found_quiet) begin
                res.start_position = '0;
                res.none_found = 1'b1;
                expected_windows.push_back(res);
            end
            write_slot = 0;
            seen_count = 0;
            found_quiet = 1'b0;
        end
    endtask

    // Send one sample beat; valid stays high across back-to-back beats
    task automatic send_sample(input logic signed [15:0] smp, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_sample      <= smp;
        s_last_sample <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_window_result(smp, last);
    endtask

    // Drop valid after the last beat and hold until every result is back
    task automatic pause_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (expected_windows.size() == 0);
    endtask

    task automatic wait_idle();
        pause_sender();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write, made only with the block idle
    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        wait_idle();
        @(negedge aclk);
        s_valid   <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (index == CFG_WINDOW_LENGTH) cur_window_length = data[8:0];
        else if (index == CFG_RANGE_THRESHOLD) cur_range_threshold = data;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        // window of 256 never fills on a short stream
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b1);
    endtask

    task automatic test_directed_extremes();
        write_reg(CFG_WINDOW_LENGTH, 16'd1);
        write_reg(CFG_RANGE_THRESHOLD, 16'd0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd0, 1'b1);
        // full-scale span just fits the widest threshold
        write_reg(CFG_WINDOW_LENGTH, 16'd2);
        write_reg(CFG_RANGE_THRESHOLD, 16'hFFFF);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b1);
        // span one above threshold: none found
        write_reg(CFG_RANGE_THRESHOLD, 16'd9);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd10, 1'b1);
        // zero length behaves as one
        write_reg(CFG_WINDOW_LENGTH, 16'd0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);
        // length above the maximum clamps; stream shorter than window
        write_reg(CFG_WINDOW_LENGTH, 16'hFFFF);
        send_sample(16'sd3, 1'b0);
        send_sample(16'sd3, 1'b1);
        write_reg(CFG_WINDOW_LENGTH, 16'd3);
        send_sample(16'sd7, 1'b1);
    endtask

    task automatic test_random_streams();
        int                 sent;
        int                 stream_len;
        int                 base;
        int                 r;
        int                 spread;
        logic signed [15:0] smp;
        sent = 0;
        while (sent < 500) begin
            r = $urandom_range(0, 19);
            no_idle = ($urandom_range(0, 5) == 0);
            if (r == 0) begin
                write_reg(CFG_WINDOW_LENGTH, 16'd256);
                stream_len = $urandom_range(257, 300);
            end else begin
                write_reg(CFG_WINDOW_LENGTH, 16'($urandom_range(1, 8)));
                stream_len = $urandom_range(1, 30);
            end
            r = $urandom_range(0, 3);
            if (r == 0) write_reg(CFG_RANGE_THRESHOLD, 16'd0);
            else if (r == 1) write_reg(CFG_RANGE_THRESHOLD, 16'hFFFF);
            else write_reg(CFG_RANGE_THRESHOLD, 16'($urandom_range(0, 40)));
            base = $urandom_range(0, 65535) - 32768;
            spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
            for (int k = 0; k < stream_len; k++) begin
                if ($urandom_range(0, 9) == 0)
                    smp = 16'($urandom_range(0, 65535));
                else
                    smp = 16'(base + $urandom_range(0, spread));
                if ($urandom_range(0, 30) == 0) pause_sender();
                send_sample(smp, k == stream_len - 1);
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    // Result channel back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        window_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_windows.size() == 0) begin
                $error("unexpected result beat: start_position %0d none_found %0b",
                       m_start_position, m_none_found);
                fail_count++;
            end else begin
                want = expected_windows.pop_front();
                if (m_start_position !== want.start_position) begin
                    $error("start_position: expected %0d, got %0d",
                           want.start_position, m_start_position);
                    fail_count++;
                end
                if (m_none_found !== want.none_found) begin
                    $error("none_found: expected %0b, got %0b",
                           want.none_found, m_none_found);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_sample = '0;
        s_last_sample = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_ready = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        fail_count = 0;
        no_idle = 1'b0;
        cur_window_length = WINDOW_LENGTH_RESET;
        cur_range_threshold = RANGE_THRESHOLD_RESET;
        write_slot = 0;
        seen_count = 0;
        found_quiet = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_directed_extremes();
        test_random_streams();

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_idle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
hdl/swrd_pkg.sv
hdl/swrd_front.sv
hdl/swrd_mono_queue.sv
hdl/swrd_back.sv
hdl/sliding_window_range_detector_top.sv
tb/sv/tb_top.sv
